// ===== hdl/cts_pkg.sv =====
// types and codes for the compacting table block
package cts_pkg;

	// command codes; the fourth code leaves the table unchanged and gets an OK result
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SCAN  = 2'd1,
		S_SHIFT = 2'd2,
		S_DONE  = 2'd3
	} state_t;

	localparam int unsigned IndexW = 4;
	localparam int unsigned CountW = 5;
	localparam int unsigned ValueW = 32;

endpackage

// ===== hdl/cts_mem.sv =====
// entry storage: one write port, one read port with registered read data
module cts_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [cts_pkg::ValueW-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic [cts_pkg::ValueW-1:0] rdata
);
	import cts_pkg::*;

	logic [ValueW-1:0] mem_q [DEPTH];
	logic [ValueW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port with registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/compacting_table_insert_remove_search.sv =====
// Compacting table with insert, remove-first-match and search-first-match.
// Command channel: cmd and value, transferred when cmd_valid is high and
// cmd_stall is low. Result channel: status, index and count, transferred
// when res_valid is high and res_stall is low. Every command gives exactly
// one result transaction.
// An insert, an unused code or a command on an empty table goes straight to
// the result register. Search and remove read one entry a cycle from index 0
// until the first match or the last entry. A remove then shifts the entries
// above the match down, one a cycle. The next command can be taken in the
// cycle after the result loads.
// One command is worked on at a time; cmd_stall is high while it is busy.
// A finished result sits in the output register while the next command is
// taken; if res_stall holds, the next command waits in its final state.
// Reset clears the entry count and the controller; entry storage is not
// cleared, since only entries below the count are ever read.
module compacting_table_insert_remove_search #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic [1:0]                  cmd,
	input  logic signed [cts_pkg::ValueW-1:0] value,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [1:0]                  status,
	output logic [cts_pkg::IndexW-1:0]  index,
	output logic [cts_pkg::CountW-1:0]  count
);
	import cts_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(DEPTH);

	state_t            state_q, state_d;
	logic [1:0]        cmd_q;
	logic [ValueW-1:0] value_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     ptr_q;
	logic              issued_s1;
	logic [AW-1:0]     addr_s1;
	logic [AW-1:0]     pos_q;
	status_t           res_status_q;

	logic              res_valid_q;
	logic [1:0]        status_q;
	logic [IndexW-1:0] index_q;
	logic [CountW-1:0] count_q;

	logic              acc;
	logic              out_free;
	logic              hit;
	logic              last;
	logic              shift_end;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [ValueW-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [ValueW-1:0] rdata;
	logic [AW+IndexW-1:0] pos_ext;
	logic [CW+CountW-1:0] used_ext;

	cts_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// handshake and scan conditions
	assign cmd_stall = (state_q != S_IDLE);
	assign acc       = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign hit       = issued_s1 && (rdata == value_q);
	assign last      = issued_s1 && ((CW'(addr_s1) + CW'(1)) == used_q);
	assign shift_end = (ptr_q >= used_q) && !issued_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if ((cmd == CMD_REMOVE || cmd == CMD_SEARCH) && used_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (cmd_q == CMD_REMOVE) ? S_SHIFT : S_DONE;
				end else if (last) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				if (shift_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we        = 1'b0;
		waddr     = used_q[AW-1:0];
		wdata     = value;
		re        = 1'b0;
		raddr     = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				we = acc && (cmd == CMD_INSERT) && (used_q < DepthC);
			end
			S_SCAN: begin
				re = (ptr_q < used_q);
			end
			S_SHIFT: begin
				re    = (ptr_q < used_q);
				we    = issued_s1;
				waddr = addr_s1 - AW'(1);
				wdata = rdata;
			end
			S_DONE: begin
				we = 1'b0;
			end
			default: we = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// read pipeline tag: only reads that stay in the same phase are used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_s1 <= 1'b0;
		end else begin
			issued_s1 <= re && (state_d == state_q);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (state_q == S_IDLE && acc && cmd == CMD_INSERT && used_q < DepthC) begin
			used_q <= used_q + CW'(1);
		end else if (state_q == S_SHIFT && shift_end) begin
			used_q <= used_q - CW'(1);
		end
	end

	// command context, scan pointer and match position
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd_q   <= cmd;
					value_q <= value;
					ptr_q   <= '0;
					pos_q   <= '0;
					if (cmd == CMD_INSERT) begin
						res_status_q <= (used_q < DepthC) ? ST_OK : ST_FULL;
					end else if ((cmd == CMD_REMOVE || cmd == CMD_SEARCH) && used_q == '0) begin
						res_status_q <= ST_EMPTY;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (re) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (hit) begin
					pos_q <= addr_s1;
					ptr_q <= CW'(addr_s1) + CW'(1);
				end else if (last) begin
					res_status_q <= ST_MISS;
				end
			end
			S_SHIFT: begin
				if (re) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			S_DONE: begin
				ptr_q <= ptr_q;
			end
			default: ptr_q <= ptr_q;
		endcase
	end

	// result register
	assign pos_ext  = (AW + IndexW)'(pos_q);
	assign used_ext = (CW + CountW)'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			index_q  <= pos_ext[IndexW-1:0];
			count_q  <= used_ext[CountW-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign index     = index_q;
	assign count     = count_q;

endmodule
